[rtl/gtf_pkg.sv]
// ----------------------------------------------------------------------------
// gtf_pkg: shared types, constants and table builder for the GELU datapath
// Holds the packed activation and result words, the pipeline control bundle,
// the fixed-point coefficients and the elaboration-time tanh table function.
// ----------------------------------------------------------------------------
`default_nettype none

package gtf_pkg;

  // Field layout of one transaction
  localparam int unsigned FIELD_LANES = 8;
  localparam int unsigned DATA_W      = 16;

  // Lane pipeline depth, plus one merge register at the end
  localparam int unsigned LANE_STAGES = 8;
  localparam int unsigned STAGES      = LANE_STAGES + 1;

  // Fixed-point coefficients (Q.24) and unity in Q.16
  localparam logic [19:0] CUBIC_Q24 = 20'd750193;
  localparam logic [23:0] SCALE_Q24 = 24'd13386282;
  localparam logic [16:0] ONE_Q16   = 17'h10000;

  typedef struct packed {
    logic signed [DATA_W-1:0] x0;
    logic signed [DATA_W-1:0] x1;
    logic signed [DATA_W-1:0] x2;
    logic signed [DATA_W-1:0] x3;
    logic signed [DATA_W-1:0] x4;
    logic signed [DATA_W-1:0] x5;
    logic signed [DATA_W-1:0] x6;
    logic signed [DATA_W-1:0] x7;
  } gtf_x_t;

  typedef struct packed {
    logic signed [DATA_W-1:0] y0;
    logic signed [DATA_W-1:0] y1;
    logic signed [DATA_W-1:0] y2;
    logic signed [DATA_W-1:0] y3;
    logic signed [DATA_W-1:0] y4;
    logic signed [DATA_W-1:0] y5;
    logic signed [DATA_W-1:0] y6;
    logic signed [DATA_W-1:0] y7;
  } gtf_y_t;

  // Per-stage load enables and the output valid
  typedef struct packed {
    logic [STAGES-1:0] en;
    logic              out_vld;
  } gtf_ctl_t;

  // Shift-subtract division, used only while building constant tables
  function automatic logic [63:0] udiv64(input logic [63:0] num, input logic [63:0] den);
    logic [64:0] rem;
    logic [63:0] quo;
    rem = '0;
    quo = '0;
    for (int b = 63; b >= 0; b--) begin
      rem = {rem[63:0], num[b]};
      if (rem >= {1'b0, den}) begin
        rem    = rem - {1'b0, den};
        quo[b] = 1'b1;
      end
    end
    return quo;
  endfunction

  // tanh(4*i/n) in unsigned Q.16, built from q = e^(-8i/n) in Q.32
  function automatic logic [15:0] tanh_point(input int unsigned n, input int unsigned i);
    logic [63:0] term;
    logic [63:0] sum;
    logic [63:0] b;
    logic [63:0] q;
    logic [63:0] num;
    logic [63:0] den;
    logic [63:0] pt;
    term = 64'd1 << 40;
    sum  = term;
    // Taylor series of e^(-8/n) in Q.40
    for (int k = 1; k <= 15; k++) begin
      term = udiv64(term * 64'd8, 64'(n) * 64'(k));
      if ((k & 1) != 0) sum = sum - term;
      else              sum = sum + term;
    end
    b = (sum + 64'd128) >> 8;
    q = 64'd1 << 32;
    for (int unsigned j = 0; j < i; j++) begin
      q = (q * b + (64'd1 << 31)) >> 32;
    end
    num = (64'd1 << 32) - q;
    den = (64'd1 << 32) + q;
    pt  = udiv64((num << 16) + (den >> 1), den);
    return pt[15:0];
  endfunction

endpackage

`default_nettype wire

[rtl/gtf_if.sv]
// ----------------------------------------------------------------------------
// gtf_if: valid/ready channels for activation and result words
// One interface per direction; each carries valid, ready and a packed word.
// ----------------------------------------------------------------------------
`default_nettype none

interface gtf_x_if;
  import gtf_pkg::*;
  logic   valid;
  logic   ready;
  gtf_x_t data;
  modport source (output valid, output data, input ready);
  modport sink   (input valid, input data, output ready);
endinterface

interface gtf_y_if;
  import gtf_pkg::*;
  logic   valid;
  logic   ready;
  gtf_y_t data;
  modport source (output valid, output data, input ready);
  modport sink   (input valid, input data, output ready);
endinterface

`default_nettype wire

[rtl/gtf_ctrl.sv]
// ----------------------------------------------------------------------------
// gtf_ctrl: valid tracking and stall control for the lane pipeline
// Keeps one valid bit per stage and lets each stage load whenever it is
// empty or its contents move on, so bubbles collapse under backpressure.
// ----------------------------------------------------------------------------
`default_nettype none

module gtf_ctrl (
  input  wire logic               clk_i,
  input  wire logic               rst_ni,
  input  wire logic               in_valid_i,
  input  wire logic               out_ready_i,
  output logic                    in_ready_o,
  output gtf_pkg::gtf_ctl_t       ctl_o
);
  import gtf_pkg::*;

  logic [STAGES-1:0] vld_q;
  logic [STAGES-1:0] vld_d;
  logic [STAGES-1:0] en;

  // Propagate load enables from the output back to the input
  always_comb begin
    en[STAGES-1] = !vld_q[STAGES-1] || out_ready_i;
    for (int k = STAGES - 2; k >= 0; k--) begin
      en[k] = !vld_q[k] || en[k+1];
    end
  end

  // Advance valid bits with their stage
  always_comb begin
    vld_d[0] = en[0] ? in_valid_i : vld_q[0];
    for (int k = 1; k < STAGES; k++) begin
      vld_d[k] = en[k] ? vld_q[k-1] : vld_q[k];
    end
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      vld_q <= '0;
    end else begin
      vld_q <= vld_d;
    end
  end

  assign in_ready_o    = en[0];
  assign ctl_o.en      = en;
  assign ctl_o.out_vld = vld_q[STAGES-1];

endmodule

`default_nettype wire

[rtl/gtf_lane.sv]
// ----------------------------------------------------------------------------
// gtf_lane: one GELU lane
// Pipelined magnitude datapath: cube, inner argument, table lookup with
// linear interpolation, then the final product and sign/saturation.
// ----------------------------------------------------------------------------
`default_nettype none

module gtf_lane #(
  parameter int unsigned TANH_ENTRIES = 256
) (
  input  wire logic                          clk_i,
  input  wire gtf_pkg::gtf_ctl_t             ctl_i,
  input  wire logic [gtf_pkg::DATA_W-1:0]    x_i,
  output logic      [gtf_pkg::DATA_W-1:0]    y_o
);
  import gtf_pkg::*;

  localparam int unsigned U_W   = 29;
  localparam int unsigned IDX_W = $clog2(TANH_ENTRIES + 1);
  localparam int unsigned POS_W = U_W + IDX_W;
  localparam int unsigned HI_W  = POS_W - 26;

  // Constant tanh table over [0,4), one extra point for interpolation
  logic [15:0] tab [TANH_ENTRIES+1];
  for (genvar i = 0; i <= TANH_ENTRIES; i++) begin : g_tab
    localparam logic [15:0] TV = tanh_point(TANH_ENTRIES, i);
    assign tab[i] = TV;
  end

  // Magnitude and sign travel alongside the datapath
  logic [16:0] a_q   [LANE_STAGES];
  logic        neg_q [LANE_STAGES];
  logic [16:0] a_d;
  logic        neg_d;

  always_comb begin
    neg_d = x_i[DATA_W-1];
    a_d   = neg_d ? (17'h10000 - {1'b0, x_i}) : {1'b0, x_i};
  end

  always_ff @(posedge clk_i) begin
    if (ctl_i.en[0]) begin
      a_q[0]   <= a_d;
      neg_q[0] <= neg_d;
    end
    for (int k = 1; k < LANE_STAGES; k++) begin
      if (ctl_i.en[k]) begin
        a_q[k]   <= a_q[k-1];
        neg_q[k] <= neg_q[k-1];
      end
    end
  end

  // Square
  logic [33:0] sq;
  logic [30:0] a2_q;
  assign sq = a_q[0] * a_q[0];
  always_ff @(posedge clk_i) begin
    if (ctl_i.en[1]) a2_q <= sq[30:0];
  end

  // Cube, rounded to Q.24
  logic [47:0] cube;
  logic [47:0] cube_r;
  logic [33:0] a3_q;
  assign cube   = a2_q * a_q[1];
  assign cube_r = cube + 48'd2048;
  always_ff @(posedge clk_i) begin
    if (ctl_i.en[2]) a3_q <= cube_r[45:12];
  end

  // Cubic term 0.044715*a^3
  logic [53:0] cprod;
  logic [53:0] cprod_r;
  logic [28:0] c_q;
  assign cprod   = a3_q * CUBIC_Q24;
  assign cprod_r = cprod + 54'(1 << 23);
  always_ff @(posedge clk_i) begin
    if (ctl_i.en[3]) c_q <= cprod_r[52:24];
  end

  // Inner argument u = sqrt(2/pi)*(a + cubic term)
  logic [28:0]  s;
  logic [52:0]  uprod;
  logic [52:0]  uprod_r;
  logic [U_W-1:0] u_q;
  assign s       = {a_q[3], 12'b0} + c_q;
  assign uprod   = s * SCALE_Q24;
  assign uprod_r = uprod + 53'(1 << 23);
  always_ff @(posedge clk_i) begin
    if (ctl_i.en[4]) u_q <= uprod_r[52:24];
  end

  // Table position: index, fraction and saturation
  logic [POS_W-1:0] pos;
  logic             sat_d;
  logic [IDX_W-1:0] idx_d;
  logic [IDX_W-1:0] idx_q;
  logic [15:0]      frac5_q;
  logic             sat5_q;
  assign pos   = POS_W'(u_q) * POS_W'(TANH_ENTRIES);
  assign sat_d = pos[POS_W-1:26] >= HI_W'(TANH_ENTRIES);
  assign idx_d = sat_d ? '0 : pos[26 +: IDX_W];
  always_ff @(posedge clk_i) begin
    if (ctl_i.en[5]) begin
      idx_q   <= idx_d;
      frac5_q <= pos[25:10];
      sat5_q  <= sat_d;
    end
  end

  // Fetch both neighboring points
  logic [IDX_W-1:0] idx_nx;
  logic [15:0]      lo;
  logic [15:0]      hi;
  logic [15:0]      lo_q;
  logic [15:0]      d_q;
  logic [15:0]      frac6_q;
  logic             sat6_q;
  assign idx_nx = idx_q + IDX_W'(1);
  assign lo     = tab[idx_q];
  assign hi     = tab[idx_nx];
  always_ff @(posedge clk_i) begin
    if (ctl_i.en[6]) begin
      lo_q    <= lo;
      d_q     <= (hi >= lo) ? (hi - lo) : 16'd0;
      frac6_q <= frac5_q;
      sat6_q  <= sat5_q;
    end
  end

  // Interpolate and clamp tanh to one
  logic [31:0] dp;
  logic [32:0] dp_r;
  logic [16:0] t_sum;
  logic [16:0] t_q;
  assign dp    = d_q * frac6_q;
  assign dp_r  = {1'b0, dp} + 33'(1 << 15);
  assign t_sum = {1'b0, lo_q} + {1'b0, dp_r[31:16]};
  always_ff @(posedge clk_i) begin
    if (ctl_i.en[7]) begin
      if (sat6_q || (t_sum > ONE_Q16)) t_q <= ONE_Q16;
      else                             t_q <= t_sum;
    end
  end

  // Final product 0.5*a*(1 +/- t), sign and saturate
  logic [17:0] f;
  logic [34:0] prod;
  logic [35:0] prod_r;
  logic [18:0] mag;
  always_comb begin
    f      = neg_q[7] ? (18'(ONE_Q16) - 18'(t_q)) : (18'(ONE_Q16) + 18'(t_q));
    prod   = a_q[7] * f;
    prod_r = {1'b0, prod} + 36'(1 << 16);
    mag    = prod_r[35:17];
    if (neg_q[7]) begin
      y_o = (mag > 19'd32768) ? 16'h8000 : 16'(~mag[15:0] + 16'd1);
    end else begin
      y_o = (mag > 19'd32767) ? 16'h7FFF : mag[15:0];
    end
  end

endmodule

`default_nettype wire

[rtl/gtf_merge.sv]
// ----------------------------------------------------------------------------
// gtf_merge: output register that gathers all lane results
// Packs the lane results into one result word, zero-filling unused lanes.
// ----------------------------------------------------------------------------
`default_nettype none

module gtf_merge #(
  parameter int unsigned LANES = 8
) (
  input  wire logic                                     clk_i,
  input  wire gtf_pkg::gtf_ctl_t                        ctl_i,
  input  wire logic [LANES-1:0][gtf_pkg::DATA_W-1:0]    lane_y_i,
  output gtf_pkg::gtf_y_t                               y_o
);
  import gtf_pkg::*;

  logic [FIELD_LANES-1:0][DATA_W-1:0] fill;
  gtf_y_t                             y_q;

  // Zero-fill lanes that are not built
  for (genvar k = 0; k < FIELD_LANES; k++) begin : g_fill
    if (k < LANES) begin : g_used
      assign fill[k] = lane_y_i[k];
    end else begin : g_unused
      assign fill[k] = '0;
    end
  end

  // Hold the result word until the transaction completes
  always_ff @(posedge clk_i) begin
    if (ctl_i.en[STAGES-1]) begin
      y_q.y0 <= fill[0];
      y_q.y1 <= fill[1];
      y_q.y2 <= fill[2];
      y_q.y3 <= fill[3];
      y_q.y4 <= fill[4];
      y_q.y5 <= fill[5];
      y_q.y6 <= fill[6];
      y_q.y7 <= fill[7];
    end
  end

  assign y_o = y_q;

endmodule

`default_nettype wire

[rtl/gelu_tanh_forward.sv]
// ----------------------------------------------------------------------------
// gelu_tanh_forward: eight-lane tanh-form GELU on signed Q3.12 activations
//
// x_i carries one packed word of activations x0..x7 per transaction; y_o
// returns the matching word y0..y7, each 0.5*x*(1+tanh(0.798*(x+0.0447*x^3)))
// rounded to nearest and saturated to Q3.12. Both channels move a
// transaction on a clock edge where valid and ready are high.
// A taken word passes through the lane stages and then the merge register,
// whose valid bit drives y_o.valid.
// Throughput: one word per cycle while y_o.ready is high; every lane is a
// fully pipelined datapath with at most one multiplier per stage, and the
// tanh table is constant logic read at two points per lane.
// When the receiver stalls, the final register holds its word and the
// stages behind it keep filling until the pipeline is full; only then does
// x_i.ready drop. Lanes at or above LANES return zero.
// Reset clears the stage valid bits, so y_o.valid is low after reset and
// x_i.ready is high as soon as reset is released.
// ----------------------------------------------------------------------------
`default_nettype none

module gelu_tanh_forward #(
  parameter int unsigned LANES        = 8,
  parameter int unsigned TANH_ENTRIES = 256
) (
  input  wire logic clk_i,
  input  wire logic rst_ni,
  gtf_x_if.sink     x_i,
  gtf_y_if.source   y_o
);
  import gtf_pkg::*;

  gtf_ctl_t                           ctl;
  logic                               in_ready;
  logic [FIELD_LANES-1:0][DATA_W-1:0] x_arr;
  logic [LANES-1:0][DATA_W-1:0]       lane_y;

  // Stall and valid control
  gtf_ctrl u_ctrl (
    .clk_i       (clk_i),
    .rst_ni      (rst_ni),
    .in_valid_i  (x_i.valid),
    .out_ready_i (y_o.ready),
    .in_ready_o  (in_ready),
    .ctl_o       (ctl)
  );

  assign x_i.ready = in_ready;

  // Unpack activations by lane
  assign x_arr[0] = x_i.data.x0;
  assign x_arr[1] = x_i.data.x1;
  assign x_arr[2] = x_i.data.x2;
  assign x_arr[3] = x_i.data.x3;
  assign x_arr[4] = x_i.data.x4;
  assign x_arr[5] = x_i.data.x5;
  assign x_arr[6] = x_i.data.x6;
  assign x_arr[7] = x_i.data.x7;

  for (genvar k = 0; k < LANES; k++) begin : g_lane
    gtf_lane #(
      .TANH_ENTRIES (TANH_ENTRIES)
    ) u_lane (
      .clk_i (clk_i),
      .ctl_i (ctl),
      .x_i   (x_arr[k]),
      .y_o   (lane_y[k])
    );
  end

  // Gather lane results into the output register
  gtf_merge #(
    .LANES (LANES)
  ) u_merge (
    .clk_i    (clk_i),
    .ctl_i    (ctl),
    .lane_y_i (lane_y),
    .y_o      (y_o.data)
  );

  assign y_o.valid = ctl.out_vld;

endmodule

`default_nettype wire
